// ===== hw/rtl/uns_pkg.sv =====
// uns_pkg: shared types, character constants and the Latin-1 letter table
// for the UTF-8 name sanitizer. No dependencies.
`timescale 1ns / 1ps

package uns_pkg;

   localparam int unsigned CP_W   = 21;
   localparam int unsigned CHAR_W = 7;

   localparam logic [CP_W-1:0]   REPL_CP = 21'h00FFFD;
   localparam logic [CHAR_W-1:0] CH_SEP  = 7'h5F;  // '_'
   localparam logic [CHAR_W-1:0] CH_U    = 7'h75;  // 'u'
   localparam logic [CHAR_W-1:0] CH_0    = 7'h30;  // '0'
   localparam logic [CHAR_W-1:0] CH_A    = 7'h41;  // 'A'

   // emit phases of the character unit
   localparam logic [2:0] PH_SEP = 3'd0;
   localparam logic [2:0] PH_CH0 = 3'd1;
   localparam logic [2:0] PH_CH1 = 3'd2;
   localparam logic [2:0] PH_U   = 3'd3;
   localparam logic [2:0] PH_HEX = 3'd4;

   typedef struct packed {
      logic [2:0]      used;  // bytes consumed, 0 = incomplete prefix
      logic [CP_W-1:0] cp;
   } dec_result_type;

   typedef struct packed {
      logic              load;
      logic [CHAR_W-1:0] ch;
      logic              no_char;
      logic              last;
   } out_load_type;

   // {second, first} letter, zero where no letter exists
   function automatic logic [2*CHAR_W-1:0] latin_map(input logic [5:0] idx);
      logic [2*CHAR_W-1:0] r;
      case (idx)
         6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5:   r = {7'h00, 7'h41};
         6'd6:                                 r = {7'h45, 7'h41};
         6'd7:                                 r = {7'h00, 7'h43};
         6'd8, 6'd9, 6'd10, 6'd11:             r = {7'h00, 7'h45};
         6'd12, 6'd13, 6'd14, 6'd15:           r = {7'h00, 7'h49};
         6'd16:                                r = {7'h00, 7'h44};
         6'd17:                                r = {7'h00, 7'h4E};
         6'd18, 6'd19, 6'd20, 6'd21, 6'd22,
         6'd24:                                r = {7'h00, 7'h4F};
         6'd25, 6'd26, 6'd27, 6'd28:           r = {7'h00, 7'h55};
         6'd29:                                r = {7'h00, 7'h59};
         6'd30:                                r = {7'h48, 7'h54};
         6'd31:                                r = {7'h73, 7'h73};
         6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
         6'd37:                                r = {7'h00, 7'h61};
         6'd38:                                r = {7'h65, 7'h61};
         6'd39:                                r = {7'h00, 7'h63};
         6'd40, 6'd41, 6'd42, 6'd43:           r = {7'h00, 7'h65};
         6'd44, 6'd45, 6'd46, 6'd47:           r = {7'h00, 7'h69};
         6'd48:                                r = {7'h00, 7'h64};
         6'd49:                                r = {7'h00, 7'h6E};
         6'd50, 6'd51, 6'd52, 6'd53, 6'd54,
         6'd56:                                r = {7'h00, 7'h6F};
         6'd57, 6'd58, 6'd59, 6'd60:           r = {7'h00, 7'h75};
         6'd61, 6'd63:                         r = {7'h00, 7'h79};
         6'd62:                                r = {7'h68, 7'h74};
         default:                              r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/uns_decode.sv =====
// uns_decode: strict UTF-8 decode of the byte queue head.
// Depends on uns_pkg.
`timescale 1ns / 1ps

module uns_decode (
   input  logic [3:0][7:0]         buf_bytes,
   input  logic [2:0]              avail,
   input  logic                    final_flag,
   output uns_pkg::dec_result_type result
);

   logic [7:0] lead;
   logic [2:0] len;
   logic       bad;
   logic       ok;
   logic [7:0] b;

   always_comb begin
      lead = buf_bytes[0];
      len  = 3'd1;
      bad  = 1'b0;
      ok   = 1'b1;
      b    = '0;
      result.used = 3'd1;
      result.cp   = {13'd0, lead};
      if (lead >= 8'hC2 && lead <= 8'hDF) begin
         len = 3'd2;
      end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
         len = 3'd3;
      end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
         len = 3'd4;
      end else if (lead >= 8'h80) begin
         bad = 1'b1;
      end
      for (int i = 1; i < 4; i++) begin
         b  = buf_bytes[i];
         ok = (b & 8'hC0) == 8'h80;
         if (i == 1) begin
            if (lead == 8'hE0 && b < 8'hA0) ok = 1'b0;
            if (lead == 8'hED && b >= 8'hA0) ok = 1'b0;
            if (lead == 8'hF0 && b < 8'h90) ok = 1'b0;
            if (lead == 8'hF4 && b >= 8'h90) ok = 1'b0;
         end
         if (3'(i) < avail && 3'(i) < len && !ok) bad = 1'b1;
      end
      if (len != 3'd1) begin
         if (bad || (avail < len && final_flag)) begin
            result.used = 3'd1;
            result.cp   = uns_pkg::REPL_CP;
         end else if (avail < len) begin
            result.used = 3'd0;
         end else begin
            result.used = len;
            case (len)
               3'd2:    result.cp = {10'd0, lead[4:0], buf_bytes[1][5:0]};
               3'd3:    result.cp = {5'd0, lead[3:0], buf_bytes[1][5:0],
                                     buf_bytes[2][5:0]};
               default: result.cp = {lead[2:0], buf_bytes[1][5:0],
                                     buf_bytes[2][5:0], buf_bytes[3][5:0]};
            endcase
         end
      end else if (bad) begin
         result.cp = uns_pkg::REPL_CP;
      end
   end

endmodule

// ===== hw/rtl/uns_char_unit.sv =====
// uns_char_unit: shared character generator, picks one output character per
// step from the emit phase (separator, letters, 'u', hex nibble). Uses uns_pkg.
`timescale 1ns / 1ps

module uns_char_unit (
   input  logic [2:0]                  phase,
   input  logic [uns_pkg::CP_W-1:0]    cp,
   input  logic [2:0]                  nib,
   input  logic [2*uns_pkg::CHAR_W-1:0] letters,
   output logic [uns_pkg::CHAR_W-1:0]  ch
);

   logic [23:0] cp_ext;
   logic [4:0]  bit_pos;
   logic [3:0]  digit;

   always_comb begin
      cp_ext  = {3'd0, cp};
      bit_pos = {nib, 2'b00};
      digit   = cp_ext[bit_pos +: 4];
      case (phase)
         uns_pkg::PH_SEP: ch = uns_pkg::CH_SEP;
         uns_pkg::PH_CH0: ch = letters[uns_pkg::CHAR_W-1:0];
         uns_pkg::PH_CH1: ch = letters[2*uns_pkg::CHAR_W-1:uns_pkg::CHAR_W];
         uns_pkg::PH_U:   ch = uns_pkg::CH_U;
         uns_pkg::PH_HEX: begin
            if (digit < 4'd10) ch = uns_pkg::CH_0 + {3'd0, digit};
            else               ch = uns_pkg::CH_A + {3'd0, digit} - 7'd10;
         end
         default:         ch = '0;
      endcase
   end

endmodule

// ===== hw/rtl/uns_seq.sv =====
// uns_seq: sequencer holding the byte queue and name state; decodes one code
// point at a time and emits its characters through uns_char_unit.
// Depends on uns_pkg, uns_decode, uns_char_unit.
`timescale 1ns / 1ps

module uns_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_byte,
   input  logic                  in_end,
   input  logic                  out_free,
   output uns_pkg::out_load_type out_load
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [3:0][7:0]                 buf_ff, buf_in;
   logic [2:0]                      cnt_ff, cnt_in;
   logic                            end_ff, end_in;
   logic                            emitted_ff, emitted_in;
   logic                            sep_ff, sep_in;
   logic                            slot_valid_ff, slot_valid_in;
   logic [uns_pkg::CHAR_W-1:0]      slot_char_ff, slot_char_in;
   logic [2:0]                      phase_ff, phase_in;
   logic [2:0]                      nib_ff, nib_in;
   logic [uns_pkg::CP_W-1:0]        cp_ff, cp_in;
   logic [2*uns_pkg::CHAR_W-1:0]    let_ff, let_in;
   logic                            hex_ff, hex_in;

   uns_pkg::dec_result_type         dec;
   logic [uns_pkg::CHAR_W-1:0]      unit_ch;
   logic [2*uns_pkg::CHAR_W-1:0]    lat;
   logic [23:0]                     cp_ext;
   logic [2:0]                      top_nib;
   logic [2:0]                      sel;
   logic                            is_alnum;
   logic                            is_latin;
   logic                            can_put;

   uns_decode u_decode (
      .buf_bytes  (buf_ff),
      .avail      (cnt_ff),
      .final_flag (end_ff),
      .result     (dec)
   );

   uns_char_unit u_char (
      .phase   (phase_ff),
      .cp      (cp_ff),
      .nib     (nib_ff),
      .letters (let_ff),
      .ch      (unit_ch)
   );

   assign in_ready = (state_ff == ST_IDLE);
   assign can_put  = !slot_valid_ff || out_free;

   always_comb begin
      cp_ext   = {3'd0, dec.cp};
      lat      = uns_pkg::latin_map(dec.cp[5:0]);
      is_alnum = (dec.cp >= 21'h61 && dec.cp <= 21'h7A) ||
                 (dec.cp >= 21'h41 && dec.cp <= 21'h5A) ||
                 (dec.cp >= 21'h30 && dec.cp <= 21'h39);
      is_latin = dec.cp >= 21'hC0 && dec.cp <= 21'hFF && lat[uns_pkg::CHAR_W-1:0] != '0;
      top_nib  = '0;
      for (int n = 0; n < 6; n++) begin
         if (cp_ext[n*4 +: 4] != 4'd0) top_nib = 3'(n);
      end
   end

   always_comb begin
      state_in      = state_ff;
      buf_in        = buf_ff;
      cnt_in        = cnt_ff;
      end_in        = end_ff;
      emitted_in    = emitted_ff;
      sep_in        = sep_ff;
      slot_valid_in = slot_valid_ff;
      slot_char_in  = slot_char_ff;
      phase_in      = phase_ff;
      nib_in        = nib_ff;
      cp_in         = cp_ff;
      let_in        = let_ff;
      hex_in        = hex_ff;
      sel           = '0;
      out_load      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid && (in_byte != 8'd0 || in_end)) begin
               end_in = in_end;
               if (in_byte != 8'd0) begin
                  buf_in[cnt_ff[1:0]] = in_byte;
                  cnt_in              = cnt_ff + 3'd1;
               end
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (cnt_ff == 3'd0 || dec.used == 3'd0) begin
               state_in = ST_FINISH;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  sel = 3'(i) + dec.used;
                  buf_in[i] = sel[2] ? 8'd0 : buf_ff[sel[1:0]];
               end
               cnt_in = cnt_ff - dec.used;
               cp_in  = dec.cp;
               nib_in = top_nib;
               if (is_alnum || is_latin) begin
                  let_in   = is_alnum ? {7'd0, dec.cp[6:0]} : lat;
                  hex_in   = 1'b0;
                  phase_in = (sep_ff && emitted_ff) ? uns_pkg::PH_SEP : uns_pkg::PH_CH0;
                  sep_in   = 1'b0;
                  state_in = ST_EMIT;
               end else if (dec.cp > 21'h7F) begin
                  hex_in   = 1'b1;
                  phase_in = emitted_ff ? uns_pkg::PH_SEP : uns_pkg::PH_U;
                  sep_in   = 1'b0;
                  state_in = ST_EMIT;
               end else begin
                  sep_in = emitted_ff;
               end
            end
         end
         ST_EMIT: begin
            if (can_put) begin
               out_load.load = slot_valid_ff;
               out_load.ch   = slot_char_ff;
               slot_valid_in = 1'b1;
               slot_char_in  = unit_ch;
               emitted_in    = 1'b1;
               case (phase_ff)
                  uns_pkg::PH_SEP: phase_in = hex_ff ? uns_pkg::PH_U : uns_pkg::PH_CH0;
                  uns_pkg::PH_CH0: begin
                     if (let_ff[2*uns_pkg::CHAR_W-1:uns_pkg::CHAR_W] != '0) begin
                        phase_in = uns_pkg::PH_CH1;
                     end else begin
                        state_in = ST_DECODE;
                     end
                  end
                  uns_pkg::PH_U:   phase_in = uns_pkg::PH_HEX;
                  uns_pkg::PH_HEX: begin
                     if (nib_ff == 3'd0) state_in = ST_DECODE;
                     else                nib_in = nib_ff - 3'd1;
                  end
                  default:         state_in = ST_DECODE;
               endcase
            end
         end
         ST_FINISH: begin
            if (end_ff) begin
               if (out_free) begin
                  out_load.load    = 1'b1;
                  out_load.ch      = slot_valid_ff ? slot_char_ff : '0;
                  out_load.no_char = !slot_valid_ff;
                  out_load.last    = 1'b1;
                  slot_valid_in    = 1'b0;
                  buf_in           = '0;
                  cnt_in           = '0;
                  end_in           = 1'b0;
                  emitted_in       = 1'b0;
                  sep_in           = 1'b0;
                  state_in         = ST_IDLE;
               end
            end else if (!slot_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load.load = 1'b1;
               out_load.ch   = slot_char_ff;
               slot_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         buf_ff        <= '0;
         cnt_ff        <= '0;
         end_ff        <= 1'b0;
         emitted_ff    <= 1'b0;
         sep_ff        <= 1'b0;
         slot_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         buf_ff        <= buf_in;
         cnt_ff        <= cnt_in;
         end_ff        <= end_in;
         emitted_ff    <= emitted_in;
         sep_ff        <= sep_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_char_ff <= slot_char_in;
      phase_ff     <= phase_in;
      nib_ff       <= nib_in;
      cp_ff        <= cp_in;
      let_ff       <= let_in;
      hex_ff       <= hex_in;
   end

endmodule

// ===== hw/rtl/utf8_name_sanitizer_unit.sv =====
// Throughput: one word in flight; req_tready is high only in the idle state.
// A zero byte without tlast is accepted and dropped; any other word is decoded
// one code point at a time, each followed by its characters, which rsp stalls
// can hold back. A word's first character passes the char slot, then rsp.
// Synchronous active-high reset clears the byte queue, name flags and output valid flags.
`timescale 1ns / 1ps

module utf8_name_sanitizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_name
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic       rsp_tuser,   // no_char
   output logic       rsp_tlast    // last_of_name
);

   uns_pkg::out_load_type       load;
   logic                        out_free;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [uns_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                        rsp_nochar_ff, rsp_nochar_in;
   logic                        rsp_last_ff, rsp_last_in;

   assign out_free = !rsp_valid_ff || rsp_tready;

   uns_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_end   (req_tlast),
      .out_free (out_free),
      .out_load (load)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_nochar_in = rsp_nochar_ff;
      rsp_last_in   = rsp_last_ff;
      if (load.load) begin
         rsp_valid_in  = 1'b1;
         rsp_char_in   = load.ch;
         rsp_nochar_in = load.no_char;
         rsp_last_in   = load.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff   <= rsp_char_in;
      rsp_nochar_ff <= rsp_nochar_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tuser  = rsp_nochar_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== dv/tb_utf8_name_sanitizer_unit.sv =====
// tb_utf8_name_sanitizer_unit: self-checking bench for the UTF-8 name sanitizer.
// Feeds names one byte per word through a predictor and compares every result
// word in order. Depends only on utf8_name_sanitizer_unit.
`timescale 1ns / 1ps

module tb_utf8_name_sanitizer_unit;

   localparam int unsigned N_DIR       = 23;
   localparam int unsigned N_RAND      = 207;
   localparam int unsigned HOLD_CYCLES = 200;
   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam logic [20:0] BAD_CP      = 21'h00FFFD;

   typedef enum logic [1:0] {CHK_MODEL, CHK_TEXT, CHK_MARK} row_check_type;

   typedef struct packed {
      logic [7:0]    in_byte;
      logic          eon;
      row_check_type chk;
      logic [2:0]    n;
      logic [47:0]   txt;
   } dir_row_type;

   typedef struct packed {
      logic [6:0] ch;
      logic       no_char;
      logic       last;
   } name_char_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   utf8_name_sanitizer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [7:0]     held_q [3];
   int unsigned    held_n;
   bit             any_out;
   bit             sep_owed;
   logic [7:0]     work_buf [4];
   name_char_type  step_q [$];
   name_char_type  sanitized_q [$];

   bit          idle_on;
   bit          hold_rsp;
   int unsigned sent_words;
   int unsigned errors;
   int unsigned quiet_cycles;

   function automatic bit is_alnum(input logic [20:0] cp);
      return (cp >= "a" && cp <= "z") || (cp >= "A" && cp <= "Z") ||
             (cp >= "0" && cp <= "9");
   endfunction

   // Latin-1 letter to one or two ASCII letters; 0 where none exists
   function automatic bit latin_letters(input logic [7:0] cpl, output logic [7:0] c0,
                                        output logic [7:0] c1);
      logic [4:0] k;
      k  = cpl[4:0];
      c0 = 8'h00;
      c1 = 8'h00;
      if (k <= 5) c0 = "A";
      else if (k == 6) begin
         c0 = "A";
         c1 = "E";
      end
      else if (k == 7) c0 = "C";
      else if (k <= 11) c0 = "E";
      else if (k <= 15) c0 = "I";
      else if (k == 16) c0 = "D";
      else if (k == 17) c0 = "N";
      else if (k == 23) return 1'b0;
      else if (k <= 24) c0 = "O";
      else if (k <= 28) c0 = "U";
      else if (k == 29) c0 = "Y";
      else if (k == 30) begin
         c0 = "T";
         c1 = "H";
      end
      else begin
         // sharp s upper half, y diaeresis lower half
         c0 = cpl[5] ? "y" : "s";
         c1 = cpl[5] ? 8'h00 : "s";
         return 1'b1;
      end
      if (cpl[5]) begin
         c0 = c0 + 8'h20;
         if (c1 != 8'h00) c1 = c1 + 8'h20;
      end
      return 1'b1;
   endfunction

   task automatic put_char(input logic [7:0] ch);
      name_char_type c;
      c.ch      = ch[6:0];
      c.no_char = 1'b0;
      c.last    = 1'b0;
      step_q.push_back(c);
      any_out = 1'b1;
   endtask

   task automatic flush_sep();
      if (sep_owed && any_out) put_char("_");
      sep_owed = 1'b0;
   endtask

   task automatic emit_cp(input logic [20:0] cp);
      logic [7:0]  c0, c1;
      logic [23:0] v;
      logic [3:0]  d;
      int          nib;
      v = {3'b000, cp};
      if (is_alnum(cp)) begin
         flush_sep();
         put_char(cp[7:0]);
      end
      else if (cp >= 21'hC0 && cp <= 21'hFF && latin_letters(cp[7:0], c0, c1)) begin
         flush_sep();
         put_char(c0);
         if (c1 != 8'h00) put_char(c1);
      end
      else if (cp > 21'h7F) begin
         sep_owed = any_out;
         flush_sep();
         put_char("u");
         nib = 5;
         while (nib > 0 && v[4*nib +: 4] == 4'h0) nib--;
         for (; nib >= 0; nib--) begin
            d = v[4*nib +: 4];
            put_char(d < 4'd10 ? "0" + d : "A" + d - 8'd10);
         end
      end
      else begin
         sep_owed = any_out;
      end
   endtask

   // bytes consumed at pos, 0 for a valid but incomplete prefix
   function automatic int unsigned decode_at(input int unsigned pos, input int unsigned avail,
                                             input bit fin, output logic [20:0] cp);
      logic [7:0]  lead, b1, b2, b3, b;
      int unsigned len, i;
      bit          ok;
      lead = work_buf[pos];
      cp   = BAD_CP;
      if (lead < 8'h80) begin
         cp = {13'd0, lead};
         return 1;
      end
      if (lead >= 8'hC2 && lead <= 8'hDF) len = 2;
      else if (lead >= 8'hE0 && lead <= 8'hEF) len = 3;
      else if (lead >= 8'hF0 && lead <= 8'hF4) len = 4;
      else return 1;
      for (i = 1; i < avail - pos && i < len; i++) begin
         b  = work_buf[pos + i];
         ok = (b[7:6] == 2'b10);
         if (i == 1) begin
            if (lead == 8'hE0 && b < 8'hA0) ok = 1'b0;
            if (lead == 8'hED && b >= 8'hA0) ok = 1'b0;
            if (lead == 8'hF0 && b < 8'h90) ok = 1'b0;
            if (lead == 8'hF4 && b >= 8'h90) ok = 1'b0;
         end
         if (!ok) return 1;
      end
      if (avail - pos < len) return fin ? 1 : 0;
      b1 = work_buf[pos + 1];
      b2 = (len > 2) ? work_buf[pos + 2] : 8'h00;
      b3 = (len > 3) ? work_buf[pos + 3] : 8'h00;
      if (len == 2) cp = {10'd0, lead[4:0], b1[5:0]};
      else if (len == 3) cp = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
      else cp = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
      return len;
   endfunction

   // results of one accepted word land in step_q
   task automatic sanitize_byte(input logic [7:0] b, input logic eon);
      int unsigned   avail, pos, used, i;
      logic [20:0]   cp;
      name_char_type c;
      step_q.delete();
      if (b == 8'h00 && !eon) return;
      avail = held_n;
      for (i = 0; i < held_n; i++) work_buf[i] = held_q[i];
      if (b != 8'h00) begin
         work_buf[avail] = b;
         avail++;
      end
      pos = 0;
      while (pos < avail) begin
         used = decode_at(pos, avail, eon, cp);
         if (used == 0) break;
         emit_cp(cp);
         pos += used;
      end
      held_n = avail - pos;
      for (i = 0; i < 3; i++) held_q[i] = (i < held_n) ? work_buf[pos + i] : 8'h00;
      if (eon) begin
         if (step_q.size() == 0) begin
            c.ch      = 7'h00;
            c.no_char = 1'b1;
            c.last    = 1'b1;
         end
         else begin
            c      = step_q.pop_back();
            c.last = 1'b1;
         end
         step_q.push_back(c);
         held_n   = 0;
         any_out  = 1'b0;
         sep_owed = 1'b0;
         for (i = 0; i < 3; i++) held_q[i] = 8'h00;
      end
   endtask

   function automatic dir_row_type mk_row(input logic [7:0] b, input logic eon,
                                          input row_check_type chk, input logic [2:0] n,
                                          input logic [47:0] txt);
      dir_row_type r;
      r.in_byte = b;
      r.eon     = eon;
      r.chk     = chk;
      r.n       = n;
      r.txt     = txt;
      return r;
   endfunction

   function automatic dir_row_type dir_row(input int idx);
      case (idx)
         0:  return mk_row(8'h00, 1'b1, CHK_MARK,  3'd0, 48'd0);    // empty name
         1:  return mk_row(8'h7A, 1'b0, CHK_TEXT,  3'd1, 48'("z"));
         2:  return mk_row(8'h2D, 1'b0, CHK_TEXT,  3'd0, 48'd0);
         3:  return mk_row(8'h30, 1'b0, CHK_TEXT,  3'd2, 48'("_0"));
         4:  return mk_row(8'h00, 1'b0, CHK_TEXT,  3'd0, 48'd0);    // zero byte, no end
         5:  return mk_row(8'hFF, 1'b0, CHK_TEXT,  3'd6, "_uFFFD"); // bad lead
         6:  return mk_row(8'hC3, 1'b0, CHK_TEXT,  3'd0, 48'd0);
         7:  return mk_row(8'h86, 1'b0, CHK_TEXT,  3'd2, 48'("AE"));
         8:  return mk_row(8'hE2, 1'b0, CHK_MODEL, 3'd0, 48'd0);
         9:  return mk_row(8'h82, 1'b0, CHK_MODEL, 3'd0, 48'd0);
         10: return mk_row(8'hAC, 1'b0, CHK_MODEL, 3'd0, 48'd0);
         11: return mk_row(8'hF4, 1'b0, CHK_MODEL, 3'd0, 48'd0);    // top code point
         12: return mk_row(8'h8F, 1'b0, CHK_MODEL, 3'd0, 48'd0);
         13: return mk_row(8'hBF, 1'b0, CHK_MODEL, 3'd0, 48'd0);
         14: return mk_row(8'hBF, 1'b1, CHK_MODEL, 3'd0, 48'd0);
         15: return mk_row(8'hE0, 1'b0, CHK_MODEL, 3'd0, 48'd0);    // overlong
         16: return mk_row(8'h80, 1'b0, CHK_MODEL, 3'd0, 48'd0);
         17: return mk_row(8'hED, 1'b0, CHK_MODEL, 3'd0, 48'd0);    // surrogate
         18: return mk_row(8'hA0, 1'b0, CHK_MODEL, 3'd0, 48'd0);
         19: return mk_row(8'hF0, 1'b0, CHK_MODEL, 3'd0, 48'd0);
         20: return mk_row(8'h90, 1'b0, CHK_MODEL, 3'd0, 48'd0);
         21: return mk_row(8'h80, 1'b0, CHK_MODEL, 3'd0, 48'd0);
         default: return mk_row(8'hFF, 1'b1, CHK_MODEL, 3'd0, 48'd0); // breaks 3 held bytes
      endcase
   endfunction

   task automatic send_word(input logic [7:0] b, input logic eon, input row_check_type chk,
                            input int unsigned n, input logic [47:0] txt);
      name_char_type c;
      int unsigned   i;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eon;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (b != 8'h00 || eon) sent_words++;
      sanitize_byte(b, eon);
      if (chk == CHK_MODEL) begin
         foreach (step_q[j]) sanitized_q.push_back(step_q[j]);
      end
      else if (chk == CHK_MARK) begin
         c.ch      = 7'h00;
         c.no_char = 1'b1;
         c.last    = 1'b1;
         sanitized_q.push_back(c);
      end
      else begin
         for (i = 0; i < n; i++) begin
            c.ch      = txt[8*(n-1-i) +: 7];
            c.no_char = 1'b0;
            c.last    = eon && (i == n - 1);
            sanitized_q.push_back(c);
         end
      end
   endtask

   function automatic logic [7:0] cont_byte(input logic [7:0] lo, input logic [7:0] hi);
      return 8'($urandom_range(lo, hi));
   endfunction

   // mostly well-formed names with random content, some broken or cut short
   task automatic send_random_name();
      logic [7:0]  nb [$];
      logic [7:0]  lead, b;
      int unsigned ntok, t, r, k, cut;
      bit          zero_end;
      ntok = $urandom_range(0, 6);
      for (t = 0; t < ntok; t++) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            k = $urandom_range(0, 61);
            nb.push_back(k < 10 ? 8'("0" + k) : k < 36 ? 8'("A" + k - 10) : 8'("a" + k - 36));
         end
         else if (r < 35) begin
            do b = 8'($urandom_range(1, 127)); while (is_alnum({13'd0, b}));
            nb.push_back(b);
         end
         else if (r < 50) begin
            nb.push_back(8'hC3);
            nb.push_back(cont_byte(8'h80, 8'hBF));
         end
         else if (r < 60) begin
            nb.push_back(cont_byte(8'hC2, 8'hDF));
            nb.push_back(cont_byte(8'h80, 8'hBF));
         end
         else if (r < 72) begin
            lead = cont_byte(8'hE0, 8'hEF);
            nb.push_back(lead);
            nb.push_back(lead == 8'hE0 ? cont_byte(8'hA0, 8'hBF) :
                         lead == 8'hED ? cont_byte(8'h80, 8'h9F) : cont_byte(8'h80, 8'hBF));
            nb.push_back(cont_byte(8'h80, 8'hBF));
         end
         else if (r < 80) begin
            lead = cont_byte(8'hF0, 8'hF4);
            nb.push_back(lead);
            nb.push_back(lead == 8'hF0 ? cont_byte(8'h90, 8'hBF) :
                         lead == 8'hF4 ? cont_byte(8'h80, 8'h8F) : cont_byte(8'h80, 8'hBF));
            nb.push_back(cont_byte(8'h80, 8'hBF));
            nb.push_back(cont_byte(8'h80, 8'hBF));
         end
         else if (r < 86) begin
            nb.push_back(8'h00);
         end
         else if (r < 94) begin
            nb.push_back(cont_byte(8'h80, 8'hFF));
            repeat ($urandom_range(0, 2)) nb.push_back(cont_byte(8'h00, 8'hFF));
         end
         else begin
            // valid sequence cut short
            lead = cont_byte(8'hE1, 8'hF3);
            cut  = (lead >= 8'hF0) ? $urandom_range(1, 3) : $urandom_range(1, 2);
            nb.push_back(lead);
            repeat (cut - 1) nb.push_back(cont_byte(8'h80, 8'h8F));
         end
      end
      zero_end = (nb.size() == 0) || ($urandom_range(0, 4) == 0);
      foreach (nb[i])
         send_word(nb[i], !zero_end && (i == nb.size() - 1), CHK_MODEL, 0, 48'd0);
      if (zero_end) send_word(8'h00, 1'b1, CHK_MODEL, 0, 48'd0);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      name_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sanitized_q.size() == 0) begin
            $error("unexpected word: out_char %h no_char %b last_of_name %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end
         else begin
            want = sanitized_q.pop_front();
            if (rsp_tdata !== {1'b0, want.ch}) begin
               $error("out_char expected %h actual %h", {1'b0, want.ch}, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== want.no_char) begin
               $error("no_char expected %b actual %b", want.no_char, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_name expected %b actual %b", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("utf8_name_sanitizer_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      dir_row_type row;
      bit          held_once;
      held_n     = 0;
      any_out    = 1'b0;
      sep_owed   = 1'b0;
      for (int i = 0; i < 3; i++) held_q[i] = 8'h00;
      idle_on    = 1'b1;
      hold_rsp   = 1'b0;
      held_once  = 1'b0;
      sent_words = 0;
      errors     = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         row = dir_row(i);
         send_word(row.in_byte, row.eon, row.chk, row.n, row.txt);
      end

      while (sent_words < N_DIR + N_RAND) begin
         idle_on = (sent_words < N_DIR + N_RAND - 40) && ($urandom_range(0, 3) != 0);
         if (!held_once && sent_words > N_DIR + 60) begin
            held_once = 1'b1;
            hold_rsp  = 1'b1;
         end
         send_random_name();
      end
      req_tvalid <= 1'b0;

      while (sanitized_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("utf8_name_sanitizer_unit: match");
      end
      else begin
         $display("utf8_name_sanitizer_unit: mismatch");
      end
      $finish;
   end

endmodule
